// File: rtl/core/ssas_pkg.sv
// shared types, constants and chase tables for the seven-segment scanner
package ssas_pkg;

  typedef enum logic [1:0] {
    CFG_TICK_PERIOD = 2'd0,
    CFG_DWELL       = 2'd1,
    CFG_PATTERN_EN  = 2'd2,
    CFG_PROGRESS_EN = 2'd3
  } cfg_idx_t;

  localparam int unsigned CFG_W = 16;

  localparam logic [15:0] TICK_PERIOD_RST = 16'd100;
  localparam logic [7:0]  DWELL_RST       = 8'd5;

  localparam logic [3:0] TWELVE_LAST   = 4'd11;
  localparam logic [3:0] FOURTEEN_LAST = 4'd13;
  localparam logic [2:0] SIX_LAST      = 3'd5;

  localparam logic [31:0] DP_DIGIT0 = 32'h0100_0000;

  function automatic logic [31:0] chase_twelve(input logic [3:0] ph);
    logic [31:0] f;
    case (ph)
      4'd0:    f = 32'h8000_0000;
      4'd1:    f = 32'h0080_0000;
      4'd2:    f = 32'h0000_8000;
      4'd3:    f = 32'h0000_0080;
      4'd4:    f = 32'h0000_0040;
      4'd5:    f = 32'h0000_0020;
      4'd6:    f = 32'h0000_0010;
      4'd7:    f = 32'h0000_1000;
      4'd8:    f = 32'h0010_0000;
      4'd9:    f = 32'h1000_0000;
      4'd10:   f = 32'h0800_0000;
      4'd11:   f = 32'h0400_0000;
      default: f = 32'h0000_0000;
    endcase
    return f;
  endfunction

  function automatic logic [31:0] chase_fourteen(input logic [3:0] ph);
    logic [31:0] f;
    case (ph)
      4'd0:    f = 32'h0C00_0000;
      4'd1:    f = 32'h6000_0000;
      4'd2:    f = 32'h000C_0000;
      4'd3:    f = 32'h0060_0000;
      4'd4:    f = 32'h0000_0C00;
      4'd5:    f = 32'h0000_6000;
      4'd6:    f = 32'h0000_000C;
      4'd7:    f = 32'h0000_0060;
      4'd8:    f = 32'h0000_000C;
      4'd9:    f = 32'h0000_6000;
      4'd10:   f = 32'h0000_0C00;
      4'd11:   f = 32'h0060_0000;
      4'd12:   f = 32'h000C_0000;
      4'd13:   f = 32'h6000_0000;
      default: f = 32'h0000_0000;
    endcase
    return f;
  endfunction

  function automatic logic [31:0] chase_four(input logic [1:0] ph);
    logic [31:0] f;
    case (ph)
      2'd0:    f = 32'h8080_8080;
      2'd1:    f = 32'h0202_0202;
      2'd2:    f = 32'h1010_1010;
      default: f = 32'h0202_0202;
    endcase
    return f;
  endfunction

  function automatic logic [31:0] chase_six(input logic [2:0] ph);
    logic [31:0] f;
    case (ph)
      3'd0:    f = 32'hFC00_0000;
      3'd1:    f = 32'h00FC_0000;
      3'd2:    f = 32'h0000_FC00;
      3'd3:    f = 32'h0000_00FC;
      3'd4:    f = 32'h0000_FC00;
      3'd5:    f = 32'h00FC_0000;
      default: f = 32'h0000_0000;
    endcase
    return f;
  endfunction

endpackage

// File: rtl/core/seven_segment_animation_scanner_top.sv
// four-digit seven-segment scan driver with chase animations
// Each input beat is one clock's millisecond flag; a beat with in_ms_pulse high advances
// the animation and scan counters, and every accepted beat yields one result beat carrying
// the one-hot digit select and the active-low segments (a in bit 7, dp in bit 0) for the
// state after that update. The block takes one beat per clock: the counter update and
// frame lookup sit between the input handshake and a single output register, so a result
// appears in the cycle after its input beat and a new input is taken in the same cycle the
// previous result is taken. Input stalls only while a result waits in the output register.
// Configuration writes act at once and should be made while no result is pending.
module seven_segment_animation_scanner_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  ssas_pkg::cfg_idx_t         cfg_index,
  input  logic [ssas_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_ms_pulse,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [3:0]                 out_digit_select,
  output logic [7:0]                 out_segment_lines
);
  import ssas_pkg::*;

  logic [15:0] tick_period_r;
  logic [7:0]  dwell_r;
  logic [3:0]  pattern_en_r;
  logic [3:0]  progress_en_r;

  logic [15:0] ms_acc_r,      ms_acc_nxt;
  logic [3:0]  ph_twelve_r,   ph_twelve_nxt;
  logic [3:0]  ph_fourteen_r, ph_fourteen_nxt;
  logic [1:0]  ph_four_r,     ph_four_nxt;
  logic [2:0]  ph_six_r,      ph_six_nxt;
  logic [1:0]  scan_r,        scan_nxt;
  logic [7:0]  dwell_cnt_r,   dwell_cnt_nxt;

  logic        out_valid_r;
  logic [3:0]  digit_sel_r,   digit_sel_nxt;
  logic [7:0]  seg_r,         seg_nxt;

  logic        in_accept;
  logic        out_accept;
  logic [15:0] period;
  logic [7:0]  dwell;
  logic [16:0] acc_inc;
  logic [8:0]  dwell_inc;
  logic        step_adv;
  logic [31:0] frame;
  logic [7:0]  frame_byte;

  assign out_accept = out_valid_r && !out_stall;
  assign in_stall   = out_valid_r && out_stall;
  assign in_accept  = in_valid && !in_stall;

  // zero periods act as one
  assign period    = (tick_period_r == 16'd0) ? 16'd1 : tick_period_r;
  assign dwell     = (dwell_r == 8'd0) ? 8'd1 : dwell_r;
  assign acc_inc   = {1'b0, ms_acc_r} + 17'd1;
  assign dwell_inc = {1'b0, dwell_cnt_r} + 9'd1;
  assign step_adv  = in_ms_pulse && (acc_inc >= {1'b0, period});

  always_comb begin
    ms_acc_nxt      = ms_acc_r;
    ph_twelve_nxt   = ph_twelve_r;
    ph_fourteen_nxt = ph_fourteen_r;
    ph_four_nxt     = ph_four_r;
    ph_six_nxt      = ph_six_r;
    scan_nxt        = scan_r;
    dwell_cnt_nxt   = dwell_cnt_r;
    if (in_ms_pulse) begin
      if (step_adv) begin
        ms_acc_nxt      = 16'd0;
        ph_twelve_nxt   = (ph_twelve_r >= TWELVE_LAST) ? 4'd0 : ph_twelve_r + 4'd1;
        ph_fourteen_nxt = (ph_fourteen_r >= FOURTEEN_LAST) ? 4'd0 : ph_fourteen_r + 4'd1;
        ph_four_nxt     = ph_four_r + 2'd1;
        ph_six_nxt      = (ph_six_r >= SIX_LAST) ? 3'd0 : ph_six_r + 3'd1;
      end else begin
        ms_acc_nxt = acc_inc[15:0];
      end
      if (dwell_inc >= {1'b0, dwell}) begin
        dwell_cnt_nxt = 8'd0;
        scan_nxt      = scan_r + 2'd1;
      end else begin
        dwell_cnt_nxt = dwell_inc[7:0];
      end
    end
  end

  // frame from the updated phases, decimal points only on even steps
  always_comb begin
    frame = 32'd0;
    if (pattern_en_r[0]) frame = frame | chase_twelve(ph_twelve_nxt);
    if (pattern_en_r[1]) frame = frame | chase_fourteen(ph_fourteen_nxt);
    if (pattern_en_r[2]) frame = frame | chase_four(ph_four_nxt);
    if (pattern_en_r[3]) frame = frame | chase_six(ph_six_nxt);
    if (!ph_four_nxt[0]) begin
      for (int i = 0; i < 4; i++) begin
        if (progress_en_r[i]) frame = frame | (DP_DIGIT0 >> (8 * i));
      end
    end
  end

  always_comb begin
    case (scan_nxt)
      2'd0:    frame_byte = frame[31:24];
      2'd1:    frame_byte = frame[23:16];
      2'd2:    frame_byte = frame[15:8];
      default: frame_byte = frame[7:0];
    endcase
    digit_sel_nxt = 4'b0001 << scan_nxt;
    seg_nxt       = ~frame_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_period_r <= TICK_PERIOD_RST;
      dwell_r       <= DWELL_RST;
      pattern_en_r  <= 4'd0;
      progress_en_r <= 4'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TICK_PERIOD: tick_period_r <= cfg_wdata;
        CFG_DWELL:       dwell_r       <= cfg_wdata[7:0];
        CFG_PATTERN_EN:  pattern_en_r  <= cfg_wdata[3:0];
        CFG_PROGRESS_EN: progress_en_r <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ms_acc_r      <= 16'd0;
      ph_twelve_r   <= 4'd0;
      ph_fourteen_r <= 4'd0;
      ph_four_r     <= 2'd0;
      ph_six_r      <= 3'd0;
      scan_r        <= 2'd0;
      dwell_cnt_r   <= 8'd0;
      out_valid_r   <= 1'b0;
    end else begin
      if (in_accept) begin
        ms_acc_r      <= ms_acc_nxt;
        ph_twelve_r   <= ph_twelve_nxt;
        ph_fourteen_r <= ph_fourteen_nxt;
        ph_four_r     <= ph_four_nxt;
        ph_six_r      <= ph_six_nxt;
        scan_r        <= scan_nxt;
        dwell_cnt_r   <= dwell_cnt_nxt;
        out_valid_r   <= 1'b1;
      end else if (out_accept) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_accept) begin
      digit_sel_r <= digit_sel_nxt;
      seg_r       <= seg_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_digit_select  = digit_sel_r;
  assign out_segment_lines = seg_r;

`ifndef SYNTHESIS
  a_sel_matches_scan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (digit_sel_r == (4'b0001 << scan_r)))
    else $error("digit select out of step with scan digit");

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ph_twelve_r <= TWELVE_LAST) && (ph_fourteen_r <= FOURTEEN_LAST) &&
    (ph_six_r <= SIX_LAST))
    else $error("chase phase past its period");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r)
    else $error("input stalled with empty output register");

  a_phases_together: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && !step_adv) |=> ($stable(ph_four_r) && $stable(ph_twelve_r)))
    else $error("phase moved without an animation step");
`endif

endmodule

// File: bench/seven_segment_animation_scanner_top_tb.sv
// self-checking bench for the seven-segment scanner: drives ms beats, predicts every scan beat
module seven_segment_animation_scanner_top_tb;
  import ssas_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;

  localparam logic [31:0] TWELVE_FRAMES [12] = '{
    32'h8000_0000, 32'h0080_0000, 32'h0000_8000, 32'h0000_0080,
    32'h0000_0040, 32'h0000_0020, 32'h0000_0010, 32'h0000_1000,
    32'h0010_0000, 32'h1000_0000, 32'h0800_0000, 32'h0400_0000};
  localparam logic [31:0] FOURTEEN_FRAMES [14] = '{
    32'h0C00_0000, 32'h6000_0000, 32'h000C_0000, 32'h0060_0000,
    32'h0000_0C00, 32'h0000_6000, 32'h0000_000C, 32'h0000_0060,
    32'h0000_000C, 32'h0000_6000, 32'h0000_0C00, 32'h0060_0000,
    32'h000C_0000, 32'h6000_0000};
  localparam logic [31:0] FOUR_FRAMES [4] = '{
    32'h8080_8080, 32'h0202_0202, 32'h1010_1010, 32'h0202_0202};
  localparam logic [31:0] SIX_FRAMES [6] = '{
    32'hFC00_0000, 32'h00FC_0000, 32'h0000_FC00,
    32'h0000_00FC, 32'h0000_FC00, 32'h00FC_0000};

  typedef struct packed {
    logic [3:0] digit_select;
    logic [7:0] segment_lines;
  } scan_beat_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  cfg_idx_t         cfg_index = CFG_TICK_PERIOD;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic             in_ms_pulse = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [3:0]       out_digit_select;
  logic [7:0]       out_segment_lines;

  // predictor copy of the registers and counters
  logic [15:0] tick_cfg;
  logic [7:0]  dwell_cfg;
  logic [3:0]  pattern_cfg;
  logic [3:0]  progress_cfg;
  logic [15:0] ms_acc;
  logic [3:0]  ph_twelve;
  logic [3:0]  ph_fourteen;
  logic [1:0]  ph_four;
  logic [2:0]  ph_six;
  logic [1:0]  scan_pos;
  logic [7:0]  dwell_cnt;

  scan_beat_t expected_scan[$];

  int fail_count = 0;
  int beats_checked = 0;
  int pulses_sent = 0;
  int reg_writes = 0;
  int cycle_count = 0;
  int hold_left = 0;
  int stall_style = 0;
  int stall_tick = 0;

  seven_segment_animation_scanner_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_ms_pulse       (in_ms_pulse),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_digit_select  (out_digit_select),
    .out_segment_lines (out_segment_lines)
  );

  always #2 clk = ~clk;

  function automatic int wrap_next(input int value, input int period);
    return (value + 1 >= period) ? 0 : value + 1;
  endfunction

  function automatic scan_beat_t step_scanner(input logic pulse);
    int          period;
    int          dwell;
    logic [31:0] frame;
    logic [7:0]  seg;
    scan_beat_t  beat;
    period = (tick_cfg == 16'd0) ? 1 : int'(tick_cfg);
    dwell  = (dwell_cfg == 8'd0) ? 1 : int'(dwell_cfg);
    if (pulse) begin
      if (int'(ms_acc) + 1 >= period) begin
        ms_acc      = '0;
        ph_twelve   = 4'(wrap_next(int'(ph_twelve), 12));
        ph_fourteen = 4'(wrap_next(int'(ph_fourteen), 14));
        ph_four     = ph_four + 2'd1;
        ph_six      = 3'(wrap_next(int'(ph_six), 6));
      end else begin
        ms_acc = ms_acc + 16'd1;
      end
      if (int'(dwell_cnt) + 1 >= dwell) begin
        dwell_cnt = '0;
        scan_pos  = scan_pos + 2'd1;
      end else begin
        dwell_cnt = dwell_cnt + 8'd1;
      end
    end
    frame = '0;
    if (pattern_cfg[0] && ph_twelve < 4'd12) frame |= TWELVE_FRAMES[ph_twelve];
    if (pattern_cfg[1] && ph_fourteen < 4'd14) frame |= FOURTEEN_FRAMES[ph_fourteen];
    if (pattern_cfg[2]) frame |= FOUR_FRAMES[ph_four];
    if (pattern_cfg[3] && ph_six < 3'd6) frame |= SIX_FRAMES[ph_six];
    // decimal points only show on even animation steps
    if (!ph_four[0]) begin
      for (int i = 0; i < 4; i++) begin
        if (progress_cfg[i]) frame |= 32'h0100_0000 >> (8 * i);
      end
    end
    seg = 8'(frame >> (8 * (3 - int'(scan_pos))));
    beat.digit_select  = 4'b0001 << scan_pos;
    beat.segment_lines = ~seg;
    return beat;
  endfunction

  // result check first, then predict the beat accepted at this edge
  always @(posedge clk) begin
    scan_beat_t want;
    if (!rst_n) begin
      tick_cfg     = TICK_PERIOD_RST;
      dwell_cfg    = DWELL_RST;
      pattern_cfg  = '0;
      progress_cfg = '0;
      ms_acc       = '0;
      ph_twelve    = '0;
      ph_fourteen  = '0;
      ph_four      = '0;
      ph_six       = '0;
      scan_pos     = '0;
      dwell_cnt    = '0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_scan.size() == 0) begin
          $error("result beat with nothing pending: digit_select %0h segment_lines %0h",
                 out_digit_select, out_segment_lines);
          fail_count++;
        end else begin
          want = expected_scan.pop_front();
          beats_checked++;
          if (out_digit_select !== want.digit_select) begin
            $error("digit_select mismatch: expected %0h actual %0h",
                   want.digit_select, out_digit_select);
            fail_count++;
          end
          if (out_segment_lines !== want.segment_lines) begin
            $error("segment_lines mismatch: expected %0h actual %0h",
                   want.segment_lines, out_segment_lines);
            fail_count++;
          end
        end
      end
      // a beat taken at this edge still sees the old register values
      if (in_valid && !in_stall) expected_scan.push_back(step_scanner(in_ms_pulse));
      if (cfg_we) begin
        case (cfg_index)
          CFG_TICK_PERIOD: tick_cfg     = cfg_wdata[15:0];
          CFG_DWELL:       dwell_cfg    = cfg_wdata[7:0];
          CFG_PATTERN_EN:  pattern_cfg  = cfg_wdata[3:0];
          CFG_PROGRESS_EN: progress_cfg = cfg_wdata[3:0];
          default: ;
        endcase
      end
    end
  end

  // receiver: long hold-offs when asked, otherwise its own stall pattern
  always @(negedge clk) begin
    stall_tick++;
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      case (stall_style)
        0:       out_stall = 1'b0;
        1:       out_stall = ($urandom_range(0, 99) < 35);
        default: out_stall = ((stall_tick % 9) < 4);
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_beat(input logic pulse);
    @(negedge clk);
    in_valid    = 1'b1;
    in_ms_pulse = pulse;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (pulse) pulses_sent++;
  endtask

  task automatic idle_gap(input int cycles);
    @(negedge clk);
    in_valid    = 1'b0;
    in_ms_pulse = 1'($urandom_range(0, 1));
    repeat (cycles - 1) @(negedge clk);
  endtask

  // drop valid and wait until every pending beat has come back
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_scan.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    reg_writes++;
  endtask

  task automatic load_config(input logic [15:0] tick, input logic [7:0] dwell,
                             input logic [3:0] pattern, input logic [3:0] progress);
    settle();
    write_reg(CFG_TICK_PERIOD, tick);
    write_reg(CFG_DWELL, {8'd0, dwell});
    write_reg(CFG_PATTERN_EN, {12'd0, pattern});
    write_reg(CFG_PROGRESS_EN, {12'd0, progress});
  endtask

  task automatic test_reset_defaults();
    send_beat(1'b0);
    send_beat(1'b1);
    send_beat(1'b1);
    send_beat(1'b0);
    send_beat(1'b1);
  endtask

  task automatic test_all_patterns();
    load_config(16'd1, 8'd1, 4'hF, 4'hF);
    for (int i = 0; i < 13; i++) send_beat(1'b1);
    send_beat(1'b0);
  endtask

  task automatic test_zero_config();
    load_config(16'd0, 8'd0, 4'b0110, 4'b1001);
    repeat (3) send_beat(1'b1);
  endtask

  task automatic test_period_lowered();
    load_config(16'd40, 8'd200, 4'b0101, 4'b1010);
    repeat (4) send_beat(1'b1);
    // counters now sit above the new periods and must wrap on the next pulse
    settle();
    write_reg(CFG_TICK_PERIOD, 16'd2);
    write_reg(CFG_DWELL, 16'd3);
    repeat (2) send_beat(1'b1);
  endtask

  task automatic test_backpressure();
    load_config(16'd2, 8'd2, 4'hF, 4'b0011);
    @(posedge clk);
    hold_left = HOLD_CYCLES;
    for (int i = 0; i < 24; i++) send_beat(1'($urandom_range(0, 1)));
    settle();
  endtask

  task automatic test_long_period();
    load_config(16'hFFFF, 8'hFF, 4'b1010, 4'b0101);
    stall_style = 0;
    // counters climb well short of the full-scale periods, frame must hold still
    for (int i = 0; i < 20; i++) send_beat(1'b1);
    send_beat(1'b0);
  endtask

  task automatic test_random_traffic();
    logic [15:0] tick;
    logic [7:0]  dwell;
    int          sent;
    int          burst;
    for (int ph = 0; ph < 5; ph++) begin
      case ($urandom_range(0, 5))
        0:       tick = 16'd0;
        1:       tick = 16'hFFFF;
        2:       tick = 16'd1;
        default: tick = 16'($urandom_range(2, 6));
      endcase
      case ($urandom_range(0, 4))
        0:       dwell = 8'd0;
        1:       dwell = 8'd255;
        default: dwell = 8'($urandom_range(1, 5));
      endcase
      load_config(tick, dwell, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
      stall_style = ph % 3;
      sent = 0;
      while (sent < 145) begin
        burst = $urandom_range(1, 24);
        for (int i = 0; i < burst; i++) begin
          send_beat($urandom_range(0, 3) != 0);
          sent++;
        end
        if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 7));
      end
      if (ph == 2) begin
        @(posedge clk);
        hold_left = HOLD_CYCLES;
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_all_patterns();
    test_zero_config();
    test_period_lowered();
    test_backpressure();
    test_random_traffic();
    test_long_period();

    settle();
    repeat (5) @(posedge clk);
    $display("checked %0d scan beats from %0d ms pulses across %0d register writes",
             beats_checked, pulses_sent, reg_writes);
    $display("included hold-offs, zero and full-scale periods and lowered periods");
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/ssas_pkg.sv
rtl/core/seven_segment_animation_scanner_top.sv
bench/seven_segment_animation_scanner_top_tb.sv
